// File: hdl/signed_int_to_radix_text_top_assert.svh
// assertion macros shared by the checker
// clocked on clk_i, disabled while rst_ni is low
`ifndef SIGNED_INT_TO_RADIX_TEXT_TOP_ASSERT_SVH
`define SIGNED_INT_TO_RADIX_TEXT_TOP_ASSERT_SVH

// implication checked in the same cycle
`define SIRT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed in %m");

// implication checked in the following cycle
`define SIRT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed in %m");

`endif

// File: hdl/sirt_pkg.sv
package sirt_pkg;

  // defaults for the top level parameters
  localparam int unsigned MAX_RADIX_DFLT  = 16;
  localparam int unsigned VALUE_BITS_DFLT = 32;

  // quotient bits resolved per divider cycle
  localparam int unsigned DIV_BITS = 8;

  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned CFG_W      = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned RADIX_W    = 5;

  localparam int unsigned RESET_RADIX = 10;
  localparam logic [CFG_W-1:0] RESET_CHARS_LO = 64'h3736_3534_3332_3130; // "01234567"
  localparam logic [CFG_W-1:0] RESET_CHARS_HI = 64'h4645_4443_4241_3938; // "89ABCDEF"
  localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RADIX    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARS_LO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHARS_HI = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_FETCH,
    ST_EMIT
  } ctrl_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;      // capture a new value
    logic div;       // run one divider chunk
    logic div_last;  // last chunk of a digit: push the remainder
    logic fetch;     // prime the digit read
    logic emit;      // load the output register
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic quot_zero;   // quotient of the finishing digit is zero
    logic last_digit;  // next character out is the final one
  } dp_stat_t;

endpackage

// File: hdl/signed_int_to_radix_text_top.sv
// sequence: after a value is taken, the divider resolves each digit in chunks of 8 quotient bits,
//   then the digit read is primed, then one character per cycle enters the output while not stalled
// one value at a time: the next is taken only once the final character is in the output register;
//   the single 8-bit-per-cycle divider serves every digit
// reset: control clears, radix 10 and digits "0123456789ABCDEF"; digit memory not reset
module signed_int_to_radix_text_top #(
  parameter int unsigned MAX_RADIX  = sirt_pkg::MAX_RADIX_DFLT,
  parameter int unsigned VALUE_BITS = sirt_pkg::VALUE_BITS_DFLT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [sirt_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sirt_pkg::CFG_W-1:0]      cfg_data_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [VALUE_BITS-1:0]    value_i,
  // output channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [sirt_pkg::CHAR_W-1:0]     character_o,
  output logic                            last_o
);

  import sirt_pkg::*;

  // command and status between sequencer and datapath
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencer: idle, divide digit by digit until the quotient is zero,
  // prime the digit read, then stream the sign and digits out.
  // the output register lets the next transaction be taken while the
  // final character of the previous one still waits
  sirt_ctrl #(
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: config registers, magnitude divider, digit stack and
  // character lookup; digits come out least significant first and are
  // read back in reverse
  sirt_datapath #(
    .MAX_RADIX  (MAX_RADIX),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .character_o (character_o),
    .last_o      (last_o)
  );

endmodule

// File: hdl/sirt_ram.sv
module sirt_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/sirt_ctrl.sv
module sirt_ctrl #(
  parameter int unsigned VALUE_BITS = sirt_pkg::VALUE_BITS_DFLT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  sirt_pkg::dp_stat_t   stat_i,
  output sirt_pkg::ctrl_cmd_t  cmd_o
);

  import sirt_pkg::*;

  localparam int unsigned DIV_CYCLES = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
  localparam int unsigned CH_W = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

  ctrl_state_e     state_q, state_d;
  logic [CH_W-1:0] chunk_q, chunk_d;
  logic            out_valid_q, out_valid_d;
  logic            chunk_last;

  assign chunk_last = (chunk_q == CH_W'(DIV_CYCLES - 1));

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_DIV: begin
        cmd_o.div      = 1'b1;
        cmd_o.div_last = chunk_last;
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
      end
      ST_EMIT: begin
        cmd_o.emit = !out_valid_q || out_ready_i;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    chunk_d = chunk_q;
    unique case (state_q)
      ST_IDLE: begin
        chunk_d = '0;
        if (in_valid_i) begin
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        chunk_d = chunk_last ? '0 : chunk_q + CH_W'(1);
        if (chunk_last && stat_i.quot_zero) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd_o.emit && stat_i.last_digit) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chunk_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chunk_q     <= chunk_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: hdl/sirt_datapath.sv
module sirt_datapath #(
  parameter int unsigned MAX_RADIX  = sirt_pkg::MAX_RADIX_DFLT,
  parameter int unsigned VALUE_BITS = sirt_pkg::VALUE_BITS_DFLT
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sirt_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [sirt_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic signed [VALUE_BITS-1:0]        value_i,
  input  sirt_pkg::ctrl_cmd_t                 cmd_i,
  output sirt_pkg::dp_stat_t                  stat_o,
  output logic [sirt_pkg::CHAR_W-1:0]         character_o,
  output logic                                last_o
);

  import sirt_pkg::*;

  localparam int unsigned DIG_W      = $clog2(MAX_RADIX);
  localparam int unsigned RAD_W      = $clog2(MAX_RADIX + 1);
  localparam int unsigned DIV_CYCLES = (VALUE_BITS + DIV_BITS - 1) / DIV_BITS;
  localparam int unsigned PAD_W      = DIV_CYCLES * DIV_BITS;
  localparam int unsigned CNT_W      = $clog2(VALUE_BITS + 1);
  localparam int unsigned IDX_W      = $clog2(VALUE_BITS);
  localparam int unsigned RAD_RST    = (RESET_RADIX > MAX_RADIX) ? MAX_RADIX : RESET_RADIX;

  // configuration
  logic [RAD_W-1:0] rad_q;
  logic [RAD_W-1:0] rad_wr;
  logic [CFG_W-1:0] chars_lo_q;
  logic [CFG_W-1:0] chars_hi_q;

  // conversion state
  logic [PAD_W-1:0] mag_q;
  logic [DIG_W-1:0] rem_q;
  logic             sign_q;
  logic [CNT_W-1:0] cnt_q;
  logic [CHAR_W-1:0] chr_q;
  logic             last_q;

  logic [VALUE_BITS-1:0] val_u;
  logic [VALUE_BITS-1:0] abs_v;
  logic [PAD_W-1:0]      mag_next;
  logic [DIG_W-1:0]      rem_c;
  logic [DIV_BITS-1:0]   qbits;

  logic             ram_re;
  logic [CNT_W-1:0] rd_cnt;
  logic [DIG_W-1:0] ram_rdata;
  logic [3:0]       dig4;
  logic [2*CFG_W-1:0] char_tab;

  // clamp the radix when written
  always_comb begin
    if (cfg_data_i[RADIX_W-1:0] < RADIX_W'(2)) begin
      rad_wr = RAD_W'(2);
    end else if (cfg_data_i[RADIX_W-1:0] > RADIX_W'(MAX_RADIX)) begin
      rad_wr = RAD_W'(MAX_RADIX);
    end else begin
      rad_wr = RAD_W'(cfg_data_i[RADIX_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q      <= RAD_W'(RAD_RST);
      chars_lo_q <= RESET_CHARS_LO;
      chars_hi_q <= RESET_CHARS_HI;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_RADIX:    rad_q      <= rad_wr;
        CFG_CHARS_LO: chars_lo_q <= cfg_data_i;
        CFG_CHARS_HI: chars_hi_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign val_u = value_i;
  assign abs_v = val_u[VALUE_BITS-1] ? (~val_u + VALUE_BITS'(1)) : val_u;

  // restoring division, DIV_BITS quotient bits per cycle from the top of mag_q
  always_comb begin
    logic [DIG_W:0] trial;
    logic [DIG_W:0] rad_ext;
    rad_ext = (DIG_W + 1)'(rad_q);
    rem_c   = rem_q;
    qbits   = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial = {rem_c, mag_q[PAD_W-1-i]};
      if (trial >= rad_ext) begin
        rem_c = DIG_W'(trial - rad_ext);
        qbits[DIV_BITS-1-i] = 1'b1;
      end else begin
        rem_c = trial[DIG_W-1:0];
      end
    end
    mag_next = (mag_q << DIV_BITS) | PAD_W'(qbits);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q <= PAD_W'(abs_v);
      rem_q <= '0;
    end else if (cmd_i.div) begin
      mag_q <= mag_next;
      rem_q <= cmd_i.div_last ? '0 : rem_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sign_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.load) begin
      sign_q <= val_u[VALUE_BITS-1];
      cnt_q  <= '0;
    end else if (cmd_i.div_last) begin
      cnt_q <= cnt_q + CNT_W'(1);
    end else if (cmd_i.emit) begin
      if (sign_q) begin
        sign_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  // digit stack, least significant digit at entry 0
  assign ram_re = cmd_i.fetch || (cmd_i.emit && !sign_q);
  assign rd_cnt = cmd_i.fetch ? (cnt_q - CNT_W'(1)) : (cnt_q - CNT_W'(2));

  sirt_ram #(
    .WIDTH (DIG_W),
    .DEPTH (VALUE_BITS)
  ) u_digits (
    .clk_i   (clk_i),
    .we_i    (cmd_i.div_last),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i (rem_c),
    .re_i    (ram_re),
    .raddr_i (rd_cnt[IDX_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign dig4     = 4'(ram_rdata);
  assign char_tab = {chars_hi_q, chars_lo_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      if (sign_q) begin
        chr_q  <= MINUS_CHAR;
        last_q <= 1'b0;
      end else begin
        chr_q  <= char_tab[{dig4, 3'b000} +: CHAR_W];
        last_q <= (cnt_q == CNT_W'(1));
      end
    end
  end

  assign stat_o.quot_zero  = (mag_next == '0);
  assign stat_o.last_digit = !sign_q && (cnt_q == CNT_W'(1));
  assign character_o       = chr_q;
  assign last_o            = last_q;

endmodule

// File: hdl/sirt_checker.sv
`include "signed_int_to_radix_text_top_assert.svh"

module sirt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] character_o,
  input logic       last_o
);

  // a stalled output transaction holds its character
  `SIRT_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
                    out_valid_o && $stable(character_o) && $stable(last_o))

  // one value at a time: busy right after a transaction is taken
  `SIRT_ASSERT_NEXT(a_busy_after_take, in_valid_i && in_ready_o, !in_ready_o)

  // the block only goes idle once the final character is presented
  `SIRT_ASSERT_NOW(a_idle_on_last, $rose(in_ready_o), out_valid_o && last_o)

endmodule

bind signed_int_to_radix_text_top sirt_checker u_sirt_checker (.*);
